FILE: rtl/slr_pkg.sv
// Package for the secret label redaction stream: constants, label table, helpers.
// Used by every module of the block; depends on nothing.
package slr_pkg;

    localparam int PatternCount = 10;
    localparam int MaxHiddenRun = 5;
    localparam int PatternChars = 8;
    localparam int QueueDepth   = 4;

    localparam logic [7:0] StarChar = 8'h2A;

    localparam logic [2:0] CfgMinHiddenRun = 3'd0;
    localparam logic [2:0] CfgPatternEnable = 3'd1;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       is_value;
    } t_cls_beat;

    typedef enum logic [2:0] {
        MODE_SEARCH = 3'b001,
        MODE_HOLD   = 3'b010,
        MODE_STAR   = 3'b100
    } t_mode;

    typedef enum logic [2:0] {
        OP_PASS  = 3'b001,
        OP_STARS = 3'b010,
        OP_DRAIN = 3'b100
    } t_op;

    // Labels are right aligned: the last label byte sits in bits [7:0].
    // The four key prefixes are given as ASCII bytes in hex.
    function automatic logic [63:0] label_bits(input int idx);
        logic [63:0] v;
        begin
            case (idx)
                0: v = 64'h736B_5F6C_6976_655F;
                1: v = 64'h736B_5F74_6573_745F;
                2: v = 64'h706B_5F6C_6976_655F;
                3: v = 64'h706B_5F74_6573_745F;
                4: v = {32'h0, "AKIA"};
                5: v = "api_key=";
                6: v = {8'h0, "apikey="};
                7: v = {8'h0, "secret="};
                8: v = {16'h0, "token="};
                default: v = {8'h0, "Bearer "};
            endcase
            return v;
        end
    endfunction

    function automatic logic [3:0] label_len(input int idx);
        logic [3:0] n;
        begin
            case (idx)
                4: n = 4'd4;
                6, 7, 9: n = 4'd7;
                8: n = 4'd6;
                default: n = 4'd8;
            endcase
            return n;
        end
    endfunction

    function automatic logic is_value_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "-" || c == "_" || c == ".";
    endfunction

endpackage

FILE: rtl/slr_stream_if.sv
// Valid/ready stream interface carrying one character beat.
// Depends on slr_pkg.
interface slr_stream_if;
    logic              valid;
    logic              ready;
    slr_pkg::t_beat    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/slr_front.sv
// Front end: accepts input beats, tags value characters, and writes a short queue.
// Depends on slr_pkg.
module slr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  slr_pkg::t_beat    i_data,
    input  logic              i_pop,
    output logic              o_q_valid,
    output slr_pkg::t_cls_beat o_q_data
);
    import slr_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    t_cls_beat              r_mem [QueueDepth];
    logic [PtrW-1:0]        r_wr, r_rd;
    logic [PtrW:0]          r_cnt;
    logic                   push;

    assign o_ready   = (r_cnt != (PtrW+1)'(QueueDepth));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{ch: i_data.ch, last: i_data.last,
                             is_value: is_value_char(i_data.ch)};
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (i_pop && o_q_valid) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(push) - (PtrW+1)'(i_pop && o_q_valid);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PtrW+1)'(QueueDepth))
        else $error("queue count above depth");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 && !push) |=> r_cnt == '0)
        else $error("queue count moved without push");
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (PtrW+1)'(QueueDepth)) |-> !push)
        else $error("push into full queue");

endmodule

FILE: rtl/slr_stage.sv
// One redaction stage for one label: window match, run hold, star and flush.
// Depends on slr_pkg.
module slr_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_idx,
    input  logic               i_enable,
    input  logic [2:0]         i_thr,
    input  logic               i_valid,
    output logic               o_ready,
    input  slr_pkg::t_beat     i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output slr_pkg::t_beat     o_data
);
    import slr_pkg::*;

    // Sequencing: a stage emits one beat per cycle unless stalled. A beat that
    // forces more than one output (run end, threshold crossing, flush) sets a
    // pending emission that drains held bytes or stars before the next input.
    logic [63:0]  r_win, n_win;
    logic [3:0]   r_fill, n_fill;
    t_mode        r_mode, n_mode;
    logic [7:0]   r_held [MaxHiddenRun];
    logic [2:0]   r_hcnt, n_hcnt;
    // pending work
    t_op          r_op, n_op;
    logic         r_busy, n_busy;
    logic [2:0]   r_pos, n_pos;         // next held index to drain
    logic [2:0]   r_stars, n_stars;     // stars left to send
    logic [7:0]   r_tail, n_tail;       // beat after drained bytes
    logic         r_tail_v, n_tail_v;
    logic         r_tail_last, n_tail_last; // last flag of the final pending beat

    t_beat        r_out, n_out;
    logic         r_out_v, n_out_v;

    logic [63:0]  lab;
    logic [3:0]   llen;
    logic [63:0]  mask;
    logic [63:0]  win_nx;
    logic [3:0]   fill_nx;
    logic         hit;
    logic         isv;
    logic         take;
    logic         can_out;
    logic [2:0]   thr_c;
    logic         restart;
    logic         held_we;

    always_comb begin
        lab  = label_bits(int'(i_idx));
        llen = label_len(int'(i_idx));
        mask = (llen >= 4'd8) ? '1 : ((64'd1 << {llen, 3'b000}) - 64'd1);
    end

    assign thr_c   = (i_thr > 3'(MaxHiddenRun)) ? 3'(MaxHiddenRun) : i_thr;
    assign can_out = !r_out_v || i_ready;
    assign o_ready = !r_busy && can_out;
    assign take    = i_valid && o_ready;
    assign isv     = is_value_char(i_data.ch);
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // window after a search step; restart clears it first
    always_comb begin
        restart = (r_mode != MODE_SEARCH) && !isv;
        win_nx  = restart ? {56'h0, i_data.ch} : {r_win[55:0], i_data.ch};
        fill_nx = restart ? 4'd1 : ((r_fill < 4'd8) ? r_fill + 4'd1 : r_fill);
        hit     = i_enable && (llen <= 4'(PatternChars)) && (fill_nx >= llen) &&
                  ((win_nx & mask) == lab);
    end

    always_comb begin
        n_win       = r_win;
        n_fill      = r_fill;
        n_mode      = r_mode;
        n_hcnt      = r_hcnt;
        n_op        = r_op;
        n_busy      = r_busy;
        n_pos       = r_pos;
        n_stars     = r_stars;
        n_tail      = r_tail;
        n_tail_v    = r_tail_v;
        n_tail_last = r_tail_last;
        n_out       = r_out;
        n_out_v     = r_out_v && !i_ready;
        held_we     = 1'b0;
        if (r_busy && can_out) begin
            n_out_v = 1'b1;
            unique case (r_op)
                OP_STARS: begin
                    n_out   = '{ch: StarChar, last: r_tail_last && (r_stars == 3'd1)};
                    n_stars = r_stars - 3'd1;
                    if (r_stars == 3'd1) n_busy = 1'b0;
                end
                OP_DRAIN: begin
                    if (r_pos < r_hcnt) begin
                        n_out = '{ch: r_held[r_pos],
                                  last: r_tail_last && !r_tail_v &&
                                        (r_pos + 3'd1 == r_hcnt)};
                        n_pos = r_pos + 3'd1;
                        if (!r_tail_v && r_pos + 3'd1 == r_hcnt) begin
                            n_busy = 1'b0;
                            n_hcnt = '0;
                        end
                    end else begin
                        n_out    = '{ch: r_tail, last: r_tail_last};
                        n_tail_v = 1'b0;
                        n_busy   = 1'b0;
                        n_hcnt   = '0;
                    end
                end
                default: begin
                    n_busy  = 1'b0;
                    n_out_v = 1'b0;
                end
            endcase
        end else if (take) begin
            unique case (r_mode)
                MODE_HOLD: begin
                    if (isv) begin
                        if (r_hcnt + 3'd1 > thr_c) begin
                            // The held bytes and this one all become stars; the
                            // first goes out now and the rest follow.
                            n_out   = '{ch: StarChar,
                                        last: i_data.last && (r_hcnt == 3'd0)};
                            n_out_v = 1'b1;
                            n_hcnt  = '0;
                            n_mode  = i_data.last ? MODE_SEARCH : MODE_STAR;
                            if (i_data.last) begin
                                n_win  = '0;
                                n_fill = '0;
                            end
                            if (r_hcnt != 3'd0) begin
                                n_busy      = 1'b1;
                                n_op        = OP_STARS;
                                n_stars     = r_hcnt;
                                n_tail_last = i_data.last;
                            end
                        end else begin
                            held_we = 1'b1;
                            n_hcnt  = r_hcnt + 3'd1;
                            if (i_data.last) begin
                                n_busy      = 1'b1;
                                n_op        = OP_DRAIN;
                                n_pos       = '0;
                                n_tail_v    = 1'b0;
                                n_tail_last = 1'b1;
                                n_mode      = MODE_SEARCH;
                                n_win       = '0;
                                n_fill      = '0;
                            end
                        end
                    end else begin
                        n_mode  = (hit && !i_data.last) ? MODE_HOLD : MODE_SEARCH;
                        n_win   = i_data.last ? '0 : win_nx;
                        n_fill  = i_data.last ? '0 : fill_nx;
                        n_out_v = 1'b1;
                        if (r_hcnt == 3'd0) begin
                            n_out = '{ch: i_data.ch, last: i_data.last};
                        end else begin
                            n_out       = '{ch: r_held[0], last: 1'b0};
                            n_busy      = 1'b1;
                            n_op        = OP_DRAIN;
                            n_pos       = 3'd1;
                            n_tail      = i_data.ch;
                            n_tail_v    = 1'b1;
                            n_tail_last = i_data.last;
                        end
                    end
                end
                default: begin
                    // search or star
                    n_out_v = 1'b1;
                    if (r_mode == MODE_STAR && isv) begin
                        n_out = '{ch: StarChar, last: i_data.last};
                    end else begin
                        n_out  = '{ch: i_data.ch, last: i_data.last};
                        n_win  = win_nx;
                        n_fill = fill_nx;
                        n_mode = hit ? MODE_HOLD : MODE_SEARCH;
                        n_hcnt = '0;
                    end
                    if (i_data.last) begin
                        n_win  = '0;
                        n_fill = '0;
                        n_mode = MODE_SEARCH;
                        n_hcnt = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (held_we) r_held[r_hcnt] <= i_data.ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_fill      <= '0;
            r_mode      <= MODE_SEARCH;
            r_hcnt      <= '0;
            r_busy      <= 1'b0;
            r_op        <= OP_PASS;
            r_out_v     <= 1'b0;
            r_pos       <= '0;
            r_stars     <= '0;
            r_tail_v    <= 1'b0;
            r_tail_last <= 1'b0;
        end else begin
            r_win       <= n_win;
            r_fill      <= n_fill;
            r_mode      <= n_mode;
            r_hcnt      <= n_hcnt;
            r_busy      <= n_busy;
            r_op        <= n_op;
            r_out_v     <= n_out_v;
            r_pos       <= n_pos;
            r_stars     <= n_stars;
            r_tail_v    <= n_tail_v;
            r_tail_last <= n_tail_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_tail <= n_tail;
    end

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready)
        else $error("input taken while draining");
    a_hcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= 3'(MaxHiddenRun))
        else $error("held count above capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> r_out_v)
        else $error("pending beat dropped");

endmodule

FILE: rtl/secret_label_redaction_stream.sv
// Top level of the secret label redaction stream: front queue plus ten stages.
// Depends on slr_pkg, slr_stream_if, slr_front and slr_stage.
//
//  Port group     Dir   Contents
//  s_in           in    char_in, last_in beats (valid/ready)
//  m_out          out   char_out, last_out beats (valid/ready)
//  cfg            in    i_cfg_we, i_cfg_idx, i_cfg_data
//
// An ordinary byte passes at one per cycle when no stage stalls; the four-entry
// front queue and each stage register it once. A run end, a threshold crossing
// or a final byte makes the stage emit the held bytes or stars one per cycle,
// holding its input meanwhile; the queue absorbs short bursts. Reset is
// synchronous and clears every stage to searching with an empty window.
// Output stalls propagate stage by stage back to the queue.
module secret_label_redaction_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slr_stream_if.sink   s_in,
    slr_stream_if.source m_out,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);
    import slr_pkg::*;

    logic [2:0]  r_thr;
    logic [9:0]  r_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 3'd4;
            r_en  <= '1;
        end else if (i_cfg_we) begin
            if ({2'b00, i_cfg_idx} == CfgMinHiddenRun) r_thr <= i_cfg_data[2:0];
            if ({2'b00, i_cfg_idx} == CfgPatternEnable) r_en <= i_cfg_data;
        end
    end

    logic      q_valid, q_pop;
    t_cls_beat q_data;

    slr_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_in.valid), .o_ready(s_in.ready), .i_data(s_in.data),
        .i_pop(q_pop), .o_q_valid(q_valid), .o_q_data(q_data)
    );

    logic  v   [PatternCount+1];
    logic  rdy [PatternCount+1];
    t_beat d   [PatternCount+1];

    assign v[0]   = q_valid;
    assign d[0]   = '{ch: q_data.ch, last: q_data.last};
    assign q_pop  = rdy[0];

    for (genvar s = 0; s < PatternCount; s++) begin : g_stage
        slr_stage u_stage (
            .i_clk, .i_rst_n,
            .i_idx(4'(s)), .i_enable(r_en[s]), .i_thr(r_thr),
            .i_valid(v[s]), .o_ready(rdy[s]), .i_data(d[s]),
            .o_valid(v[s+1]), .i_ready(rdy[s+1]), .o_data(d[s+1])
        );
    end

    assign m_out.valid = v[PatternCount];
    assign m_out.data  = d[PatternCount];
    assign rdy[PatternCount] = m_out.ready;

endmodule

FILE: sim/secret_label_redaction_stream_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the secret label redaction stream.
// Needs slr_pkg, slr_stream_if and the block's RTL; it has its own
// predictor for the ten label stages.
module secret_label_redaction_stream_tb;
    import slr_pkg::*;

    localparam int NStages = 10;
    localparam int HeldMax = 5;
    localparam int WinBytes = 8;
    localparam int DrainCycles = 80;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [9:0] i_cfg_data;

    slr_stream_if s_in();
    slr_stream_if m_out();

    secret_label_redaction_stream u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (s_in.sink),
        .m_out      (m_out.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The label table, in stage order; the key prefixes are built from pieces.
    string label_txt [NStages] = '{{"sk", "_live_"}, {"sk", "_test_"},
                                   {"pk", "_live_"}, {"pk", "_test_"}, "AKIA",
                                   "api_key=", "apikey=", "secret=", "token=", "Bearer "};

    // Predictor copy of the configuration and the per-stage state.
    logic [2:0]  thr_reg;
    logic [9:0]  enable_reg;
    logic [63:0] win      [NStages];
    int          fill     [NStages];
    t_mode       mode     [NStages];
    logic [7:0]  held     [NStages][HeldMax];
    int          held_cnt [NStages];

    t_beat redacted_q[$];   // expected output beats, oldest first
    t_beat stage_out[$];    // scratch list produced by one stage

    int n_in_beats, n_out_beats, n_bad, n_stars_seen, n_last_seen;
    bit stall_done;

    function automatic bit value_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h5F || c == 8'h2E;
    endfunction

    function automatic void emit(input logic [7:0] c);
        t_beat b;
        b.ch = c;
        b.last = 1'b0;
        stage_out.push_back(b);
    endfunction

    function automatic bit label_hit(input int s);
        int len;
        len = label_txt[s].len();
        if (len > WinBytes || fill[s] < len) return 1'b0;
        for (int k = 0; k < len; k++)
            if (win[s][8*(len-1-k) +: 8] != label_txt[s].getc(k)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void scan_byte(input int s, input logic [7:0] c);
        win[s] = {win[s][55:0], c};
        if (fill[s] < WinBytes) fill[s]++;
        emit(c);
        if (enable_reg[s] && label_hit(s)) begin
            mode[s] = MODE_HOLD;
            held_cnt[s] = 0;
        end
    endfunction

    function automatic void clear_lane(input int s);
        win[s] = '0;
        fill[s] = 0;
        mode[s] = MODE_SEARCH;
        held_cnt[s] = 0;
    endfunction

    function automatic void flush_held(input int s);
        for (int k = 0; k < held_cnt[s]; k++) emit(held[s][k]);
        held_cnt[s] = 0;
    endfunction

    function automatic void lane_feed(input int s, input logic [7:0] c, input logic lst);
        int lim;
        lim = (thr_reg > HeldMax) ? HeldMax : int'(thr_reg);
        if (mode[s] == MODE_HOLD) begin
            if (value_byte(c)) begin
                if (held_cnt[s] + 1 > lim) begin
                    for (int k = 0; k <= held_cnt[s]; k++) emit(StarChar);
                    held_cnt[s] = 0;
                    mode[s] = MODE_STAR;
                end else begin
                    held[s][held_cnt[s]] = c;
                    held_cnt[s]++;
                end
            end else begin
                flush_held(s);
                clear_lane(s);
                scan_byte(s, c);
            end
        end else if (mode[s] == MODE_STAR) begin
            if (value_byte(c)) begin
                emit(StarChar);
            end else begin
                clear_lane(s);
                scan_byte(s, c);
            end
        end else begin
            scan_byte(s, c);
        end
        if (lst) begin
            flush_held(s);
            clear_lane(s);
            if (stage_out.size() > 0) stage_out[stage_out.size()-1].last = 1'b1;
        end
    endfunction

    // Push one accepted input beat through all ten stages.
    function automatic void redact_beat(input t_beat b);
        t_beat cur[$];
        cur.push_back(b);
        for (int s = 0; s < NStages; s++) begin
            stage_out.delete();
            foreach (cur[i]) lane_feed(s, cur[i].ch, cur[i].last);
            cur = stage_out;
        end
        foreach (cur[i]) redacted_q.push_back(cur[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Sender: one beat, then an optional gap. Inputs move on the falling edge.
    task automatic send_beat(input logic [7:0] c, input logic lst);
        int g;
        @(negedge i_clk);
        s_in.valid <= 1'b1;
        s_in.data <= '{ch: c, last: lst};
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        redact_beat('{ch: c, last: lst});
        n_in_beats++;
        g = pick_gap();
        if (g > 0) begin
            @(negedge i_clk);
            s_in.valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_text(input string t, input bit end_text);
        for (int i = 0; i < t.len(); i++)
            send_beat(t.getc(i), end_text && (i == t.len() - 1));
    endtask

    // Stop offering, wait until every expected beat is out, then let a held
    // run settle.
    task automatic settle();
        int guard;
        @(negedge i_clk);
        s_in.valid <= 1'b0;
        guard = 0;
        while (redacted_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [9:0] val);
        @(negedge i_clk);
        s_in.valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgMinHiddenRun[0]) thr_reg = val[2:0];
        else enable_reg = val;
    endtask

    function automatic string value_run(input int n);
        string v, pool;
        pool = "abcXYZ0189-_.";
        v = "";
        for (int i = 0; i < n; i++)
            v = {v, string'(pool.getc($urandom_range(pool.len() - 1)))};
        return v;
    endfunction

    // One random text: mostly labels followed by value runs, some noise.
    task automatic send_random_text();
        int pieces, r, lab;
        string t;
        pieces = $urandom_range(6, 1);
        for (int p = 0; p < pieces; p++) begin
            r = $urandom_range(99);
            lab = $urandom_range(NStages - 1);
            if (r < 65) begin
                t = {label_txt[lab], value_run($urandom_range(8))};
            end else if (r < 80) begin
                // Broken label: cut short, sometimes followed by two value bytes.
                t = label_txt[lab].substr(0, $urandom_range(label_txt[lab].len() - 2));
                if ($urandom_range(1)) t = {t, value_run(2)};
            end else begin
                t = "";
                repeat ($urandom_range(4, 1)) t = {t, string'(8'($urandom_range(255)))};
            end
            if ($urandom_range(3) != 0)
                t = {t, string'(8'($urandom_range(1) ? 8'h20 : 8'h3B))};
            send_text(t, 1'b0);
        end
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    // Directed texts: four of the labels, three with short value runs.
    string direct_rows [4] = '{"AKIA12345\n", "token=abc;", "Bearer x", {"sk", "_test_"}};

    // Receiver: ready moves on the falling edge, with one long hold-off
    // once the random traffic is flowing so the block backs up.
    initial begin
        int g;
        m_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!stall_done && n_in_beats > 200) begin
                stall_done = 1'b1;
                m_out.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end else begin
                g = pick_gap();
                if (g == 0) begin
                    m_out.ready <= 1'b1;
                end else begin
                    m_out.ready <= 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Checker: compare each output beat with the oldest expectation.
    initial begin
        t_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_out.valid && m_out.ready) begin
                n_out_beats++;
                if (m_out.data.ch == StarChar) n_stars_seen++;
                if (m_out.data.last) n_last_seen++;
                if (redacted_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected beat ch=%h last=%b", m_out.data.ch,
                                 m_out.data.last);
                end else begin
                    want = redacted_q.pop_front();
                    if (want.ch !== m_out.data.ch || want.last !== m_out.data.last) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("beat %0d: expected ch=%h last=%b, got ch=%h last=%b",
                                     n_out_beats, want.ch, want.last, m_out.data.ch,
                                     m_out.data.last);
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        n_in_beats = 0; n_out_beats = 0; n_bad = 0;
        n_stars_seen = 0; n_last_seen = 0; stall_done = 1'b0;
        s_in.valid = 1'b0;
        s_in.data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        thr_reg = 3'd4;
        enable_reg = 10'h3FF;
        for (int s = 0; s < NStages; s++) clear_lane(s);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings.
        foreach (direct_rows[i]) send_text(direct_rows[i], 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        settle();

        // A threshold lowered in the middle of a held run stars it at once.
        send_text("secret=ab", 1'b0);
        settle();
        write_reg(CfgMinHiddenRun[0], 10'd0);
        send_text("cd;", 1'b1);
        settle();

        // A stage enabled mid-text can match a label begun while disabled.
        write_reg(CfgPatternEnable[0], 10'h000);
        send_text("apike", 1'b0);
        settle();
        write_reg(CfgPatternEnable[0], 10'h3FF);
        send_text("y=zzzzzz.", 1'b1);
        settle();

        // Random part across several settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CfgMinHiddenRun[0], 10'd4); end
                1: begin write_reg(CfgMinHiddenRun[0], 10'd5); end
                2: begin write_reg(CfgMinHiddenRun[0], 10'd7);
                         write_reg(CfgPatternEnable[0], 10'h2AA); end
                3: begin write_reg(CfgMinHiddenRun[0], 10'd0);
                         write_reg(CfgPatternEnable[0], 10'h155); end
                4: begin write_reg(CfgMinHiddenRun[0], 10'd2);
                         write_reg(CfgPatternEnable[0], 10'h000); end
                default: begin write_reg(CfgMinHiddenRun[0], 10'd1);
                               write_reg(CfgPatternEnable[0], 10'h3FF); end
            endcase
            while (n_in_beats < 60 + 70 * (ph + 1)) send_random_text();
            settle();
        end

        $display("Run covered %0d input beats and %0d output beats, %0d of them stars,",
                 n_in_beats, n_out_beats, n_stars_seen);
        $display("over %0d texts under eight register settings, %0d mismatches.",
                 n_last_seen, n_bad);
        if (n_bad == 0 && redacted_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
